// ----- rtl/bdf_pkg.sv -----
package bdf_pkg;

  // Phase codes
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_PRESS   = 3'd1;
  localparam logic [2:0] PH_POLL    = 3'd2;
  localparam logic [2:0] PH_RELEASE = 3'd3;
  localparam logic [2:0] PH_ENABLE  = 3'd4;

  // Request codes
  localparam logic [1:0] REQ_EDGE = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_TAKE = 2'd2;

  // Pending-line patterns and line levels
  localparam logic [3:0] PAT_LEFT       = 4'd4;
  localparam logic [3:0] PAT_RIGHT      = 4'd8;
  localparam logic [1:0] LINES_RELEASED = 2'b11;

  // Button codes
  localparam logic [1:0] BTN_NONE  = 2'd0;
  localparam logic [1:0] BTN_LEFT  = 2'd1;
  localparam logic [1:0] BTN_RIGHT = 2'd2;

  // Register indexes and reset values
  localparam logic [1:0] REG_PRESS_WAIT   = 2'd0;
  localparam logic [1:0] REG_POLL_PERIOD  = 2'd1;
  localparam logic [1:0] REG_RELEASE_WAIT = 2'd2;

  localparam logic [7:0] PRESS_WAIT_RST   = 8'd15;
  localparam logic [7:0] POLL_PERIOD_RST  = 8'd10;
  localparam logic [7:0] RELEASE_WAIT_RST = 8'd20;

  typedef struct packed {
    logic [7:0] press_wait;
    logic [7:0] poll_period;
    logic [7:0] release_wait;
  } cfg_t;

  typedef struct packed {
    logic [1:0] pressed_button;
    logic       held;
    logic       edge_enabled;
    logic [2:0] phase;
  } res_t;

endpackage

// ----- rtl/bdf_core.sv -----
module bdf_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [1:0]      req_type,
  input  logic [3:0]      pending_lines,
  input  logic [1:0]      line_levels,
  input  bdf_pkg::cfg_t   cfg,
  output bdf_pkg::res_t   res
);
  import bdf_pkg::*;

  logic [2:0] phase_r, phase_nxt;
  logic [7:0] wait_r, wait_nxt;
  logic [1:0] latch_r, latch_nxt;
  logic       held_r, held_nxt;
  logic       edge_en_r, edge_en_nxt;
  logic [7:0] wait_dec;

  assign wait_dec = wait_r - 8'd1;

  // Work out the state after this item
  always_comb begin
    phase_nxt   = phase_r;
    wait_nxt    = wait_r;
    latch_nxt   = latch_r;
    held_nxt    = held_r;
    edge_en_nxt = edge_en_r;
    case (req_type)
      REQ_EDGE: begin
        if (edge_en_r) begin
          edge_en_nxt = 1'b0;
          if (pending_lines == PAT_LEFT) begin
            latch_nxt = BTN_LEFT;
          end else if (pending_lines == PAT_RIGHT) begin
            latch_nxt = BTN_RIGHT;
          end
          held_nxt  = 1'b1;
          wait_nxt  = cfg.press_wait;
          phase_nxt = PH_PRESS;
        end
      end
      REQ_TICK: begin
        case (phase_r)
          PH_PRESS: begin
            wait_nxt = wait_dec;
            if (wait_dec == 8'd0) begin
              phase_nxt = PH_POLL;
              wait_nxt  = cfg.poll_period;
            end
          end
          PH_POLL: begin
            wait_nxt = wait_dec;
            if (wait_dec == 8'd0) begin
              if (line_levels == LINES_RELEASED) begin
                phase_nxt = PH_RELEASE;
                wait_nxt  = cfg.release_wait;
                held_nxt  = 1'b0;
              end else begin
                wait_nxt = cfg.poll_period;
              end
            end
          end
          PH_RELEASE: begin
            wait_nxt = wait_dec;
            if (wait_dec == 8'd0) begin
              phase_nxt = PH_ENABLE;
            end
          end
          PH_ENABLE: begin
            wait_nxt    = 8'd0;
            phase_nxt   = PH_IDLE;
            edge_en_nxt = 1'b1;
          end
          default: begin
          end
        endcase
      end
      REQ_TAKE: begin
        latch_nxt = BTN_NONE;
      end
      default: begin
      end
    endcase
  end

  // Report the latch before the item and the flags after it
  always_comb begin
    res.pressed_button = latch_r;
    res.held           = held_nxt;
    res.edge_enabled   = edge_en_nxt;
    res.phase          = phase_nxt;
  end

  // Advance state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      wait_r    <= 8'd0;
      latch_r   <= BTN_NONE;
      held_r    <= 1'b0;
      edge_en_r <= 1'b1;
    end else if (step) begin
      phase_r   <= phase_nxt;
      wait_r    <= wait_nxt;
      latch_r   <= latch_nxt;
      held_r    <= held_nxt;
      edge_en_r <= edge_en_nxt;
    end
  end

  // Detection is off exactly while a sequence runs
  a_enable_idle: assert property (@(posedge clk) disable iff (!rst_n)
    edge_en_r == (phase_r == PH_IDLE))
    else $error("edge enable out of step with phase");

  // Held only during press settle or polling
  a_held_phase: assert property (@(posedge clk) disable iff (!rst_n)
    held_r |-> (phase_r == PH_PRESS || phase_r == PH_POLL))
    else $error("held flag outside press phases");

  // Counter is clear while idle
  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (wait_r == 8'd0))
    else $error("wait counter not clear in idle");

  // Latch only changes on an accepted item
  a_latch_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(latch_r))
    else $error("button latch moved without an item");

endmodule

// ----- rtl/button_debounce_fsm.sv -----
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_ready  | req_type, pending_lines, line_levels
// out     | output    | out_valid / out_ready| pressed_button, held, edge_enabled, phase
// cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item per cycle while in_ready is high: the state step is a single compare and
// decrement, and its result is registered into the output register, or the skid on a stall.
// A two-entry output buffer (output register plus skid) lets an item be taken
// while a result waits; in_ready drops only when both entries are full.
// Reset (rst_n low, synchronous) clears the phase, counter, latch and flags,
// enables edge detection and loads the register defaults 15, 10 and 20.
// cfg_ready is always high; writes to index 3 are ignored.
module button_debounce_fsm (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  logic [3:0] in_pending_lines,
  input  logic [1:0] in_line_levels,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_pressed_button,
  output logic       out_held,
  output logic       out_edge_enabled,
  output logic [2:0] out_phase,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import bdf_pkg::*;

  cfg_t cfg_r;
  res_t res;
  res_t out_r, out_nxt;
  res_t skid_r, skid_nxt;
  logic out_v_r, out_v_nxt;
  logic skid_v_r, skid_v_nxt;
  logic acc;
  logic out_take;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_v_r;
  assign acc       = in_valid && in_ready;
  assign out_take  = out_v_r && out_ready;

  // Hold the wait registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_wait   <= PRESS_WAIT_RST;
      cfg_r.poll_period  <= POLL_PERIOD_RST;
      cfg_r.release_wait <= RELEASE_WAIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PRESS_WAIT:   cfg_r.press_wait   <= cfg_data;
        REG_POLL_PERIOD:  cfg_r.poll_period  <= cfg_data;
        REG_RELEASE_WAIT: cfg_r.release_wait <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bdf_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (acc),
    .req_type      (in_req_type),
    .pending_lines (in_pending_lines),
    .line_levels   (in_line_levels),
    .cfg           (cfg_r),
    .res           (res)
  );

  // Steer each result to the output register or, on a stall, the skid; skid drains first
  always_comb begin
    out_nxt    = out_r;
    out_v_nxt  = out_v_r;
    skid_nxt   = skid_r;
    skid_v_nxt = skid_v_r;
    if (!out_v_r || out_take) begin
      if (skid_v_r) begin
        out_nxt    = skid_r;
        out_v_nxt  = 1'b1;
        skid_v_nxt = 1'b0;
      end else if (acc) begin
        out_nxt   = res;
        out_v_nxt = 1'b1;
      end else begin
        out_v_nxt = 1'b0;
      end
    end else if (acc) begin
      skid_nxt   = res;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid          = out_v_r;
  assign out_pressed_button = out_r.pressed_button;
  assign out_held           = out_r.held;
  assign out_edge_enabled   = out_r.edge_enabled;
  assign out_phase          = out_r.phase;

  // Skid never fills ahead of the output register
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds an item with output empty");

  // An accepted item always leaves the output valid next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_v_r)
    else $error("accepted item produced no result");

  // Skid fills when an accepted item meets a stalled output
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (!skid_v_r && out_v_r && !out_ready && acc) |=> skid_v_r)
    else $error("stalled result lost");

endmodule
